@@ hw/rtl/jac_pkg.sv @@
// Shared types, constants and helpers for the joystick auto-calibrating cursor block.
package jac_pkg;

   // Field widths fixed by the request and response formats
   localparam int RAW_W      = 10;
   localparam int BTN_W      = 2;
   localparam int LEVEL_W    = 4;
   localparam int CUR_X_W    = 7;
   localparam int CUR_Y_W    = 5;
   localparam int THR_W      = 4;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 7;

   // Parameter defaults
   localparam int AXIS_BITS_DEF = 10;
   localparam int LEVELS_DEF    = 6;

   // Level codes
   localparam logic [LEVEL_W-1:0] CENTRE_LEVEL = 4'd3;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 4'd15;

   // Both buttons pressed (active low)
   localparam logic [BTN_W-1:0] BTN_BOTH_PRESSED = 2'b00;

   // Reset values
   localparam logic [CUR_X_W-1:0] POS_X_RESET   = 7'd39;
   localparam logic [CUR_Y_W-1:0] POS_Y_RESET   = 5'd12;
   localparam logic [CUR_X_W-1:0] X_LIMIT_RESET = 7'd78;
   localparam logic [CUR_Y_W-1:0] Y_LIMIT_RESET = 5'd24;
   localparam logic [THR_W-1:0]   LOW_THR_RESET = 4'd2;
   localparam logic [THR_W-1:0]   HIGH_THR_RESET = 4'd5;

   // Configuration register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_X_LIMIT  = 2'd0,
      CSR_Y_LIMIT  = 2'd1,
      CSR_LOW_THR  = 2'd2,
      CSR_HIGH_THR = 2'd3
   } csr_index_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_STEP,
      ST_LPREP,
      ST_LEVEL,
      ST_COMMIT
   } jac_state_type;

   // Commands from the sequencer to the datapath
   typedef struct packed {
      logic load;    // capture request, update min/max
      logic prep;    // form range and offset
      logic step;    // range / LEVELS by reciprocal multiply
      logic lprep;   // set up the level divide
      logic level;   // one bit of offset / step
      logic commit;  // move cursor, fill response register
   } jac_cmd_type;

   // Status from the datapath to the sequencer
   typedef struct packed {
      logic out_free;  // response register can take a new result
   } jac_sts_type;

   // Stored axis width: samples wrap at AXIS_BITS, never wider than the raw field
   function automatic int axis_width(input int axis_bits);
      return (axis_bits < RAW_W) ? axis_bits : RAW_W;
   endfunction

   // Width of the level quotient: offset / step stays below 2 * LEVELS
   function automatic int rem_width(input int levels);
      return $clog2(2 * levels);
   endfunction

endpackage

@@ hw/rtl/jac_if.sv @@
// Handshake channel interfaces: request, response and register write.
interface jac_req_if;
   logic                        valid;
   logic                        ready;
   logic [jac_pkg::RAW_W-1:0]   raw_x;
   logic [jac_pkg::RAW_W-1:0]   raw_y;
   logic [jac_pkg::BTN_W-1:0]   buttons;

   modport source (output valid, output raw_x, output raw_y, output buttons, input ready);
   modport sink   (input valid, input raw_x, input raw_y, input buttons, output ready);
endinterface

interface jac_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [jac_pkg::LEVEL_W-1:0]   level_x;
   logic [jac_pkg::LEVEL_W-1:0]   level_y;
   logic [jac_pkg::CUR_X_W-1:0]   cursor_x;
   logic [jac_pkg::CUR_Y_W-1:0]   cursor_y;
   logic                          quit;

   modport source (output valid, output level_x, output level_y, output cursor_x,
                   output cursor_y, output quit, input ready);
   modport sink   (input valid, input level_x, input level_y, input cursor_x,
                   input cursor_y, input quit, output ready);
endinterface

interface jac_csr_if;
   logic                             valid;
   logic                             ready;
   logic [jac_pkg::CSR_ADDR_W-1:0]   index;
   logic [jac_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/joystick_autocal_cursor_top.sv @@
// Top level of the joystick auto-calibrating cursor block.
//
//  channel   | direction | handshake     | payload
//  ----------+-----------+---------------+------------------------------------------
//  req_chan  | in        | valid/ready   | raw_x, raw_y, buttons
//  rsp_chan  | out       | valid/ready   | level_x, level_y, cursor_x, cursor_y, quit
//  csr_chan  | in        | valid/ready   | index, data (ready always high)
//
// One request runs from acceptance through the prep, step, level-prep, level and commit states
// to the response register; the next request is taken once the sequencer is back in idle.
// Both axes work in parallel; the bit-serial divide forms an RW = clog2(2*LEVELS) bit quotient.
// One request is in flight at a time; a held response stalls only the commit step.
// Reset is synchronous; it restores registers, cursor and the uncalibrated state.
module joystick_autocal_cursor_top #(
   parameter int AXIS_BITS = jac_pkg::AXIS_BITS_DEF,
   parameter int LEVELS    = jac_pkg::LEVELS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   jac_req_if.sink    req_chan,
   jac_rsp_if.source  rsp_chan,
   jac_csr_if.sink    csr_chan
);
   import jac_pkg::*;

   jac_cmd_type cmd;
   jac_sts_type sts;

   jac_ctrl #(.LEVELS(LEVELS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   jac_dp #(.AXIS_BITS(AXIS_BITS), .LEVELS(LEVELS)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .raw_x    (req_chan.raw_x),
      .raw_y    (req_chan.raw_y),
      .buttons  (req_chan.buttons),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

endmodule

@@ hw/rtl/jac_ctrl.sv @@
// Sequencer for the calibration, divide and cursor-update steps of one request.
module jac_ctrl #(
   parameter int LEVELS    = jac_pkg::LEVELS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output jac_pkg::jac_cmd_type cmd,
   input  jac_pkg::jac_sts_type sts
);
   import jac_pkg::*;

   localparam int RW = rem_width(LEVELS);
   localparam int CW = $clog2(RW);

   jac_state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   // Next state and bit counter
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = ST_STEP;
         end
         ST_STEP: begin
            state_in = ST_LPREP;
         end
         ST_LPREP: begin
            state_in = ST_LEVEL;
            cnt_in   = CW'(RW - 1);
         end
         ST_LEVEL: begin
            if (cnt_ff == '0) state_in = ST_COMMIT;
            else cnt_in = cnt_ff - 1'b1;
         end
         ST_COMMIT: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Decode commands
   always_comb begin
      req_ready  = (state_ff == ST_IDLE);
      cmd        = '0;
      cmd.load   = (state_ff == ST_IDLE) && req_valid;
      cmd.prep   = (state_ff == ST_PREP);
      cmd.step   = (state_ff == ST_STEP);
      cmd.lprep  = (state_ff == ST_LPREP);
      cmd.level  = (state_ff == ST_LEVEL);
      cmd.commit = (state_ff == ST_COMMIT) && sts.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

@@ hw/rtl/jac_axis.sv @@
// One axis lane: running min/max, reciprocal range/LEVELS and bit-serial offset/step divide.
module jac_axis #(
   parameter int AXIS_BITS = jac_pkg::AXIS_BITS_DEF,
   parameter int LEVELS    = jac_pkg::LEVELS_DEF
) (
   input  logic                         clock,
   input  jac_pkg::jac_cmd_type         cmd,
   input  logic                         seeded,
   input  logic [jac_pkg::RAW_W-1:0]    raw,
   output logic [jac_pkg::LEVEL_W-1:0]  level
);
   import jac_pkg::*;

   localparam int AW = axis_width(AXIS_BITS);
   localparam int RW = rem_width(LEVELS);
   localparam int DW = AW + RW - 1;
   localparam int QW = (RW > LEVEL_W) ? RW : LEVEL_W;
   // Reciprocal of LEVELS, exact for every range below 2**AW
   localparam int SH = AW + $clog2(LEVELS);
   localparam int MW = AW + 1;
   localparam int PW = AW + MW;
   localparam logic [MW-1:0] RECIP = MW'(((2 ** SH) + LEVELS - 1) / LEVELS);

   logic [AW-1:0] raw_ff, lo_ff, hi_ff, num_ff, diff_ff;
   logic [RW-1:0] q_ff;
   logic [DW-1:0] dv_ff;

   logic [AW-1:0] raw_m;
   logic [PW-1:0] scaled;
   logic          lvl_ge;
   logic [QW-1:0] q_wide;

   // Wrap sample to the axis width
   assign raw_m = AW'(raw);

   // Range / LEVELS as a multiply by the reciprocal
   assign scaled = PW'(num_ff) * PW'(RECIP);

   // Restoring divide step for offset / step
   assign lvl_ge = (DW'(diff_ff) >= dv_ff);

   // Saturate level, centre when the step is zero
   assign q_wide = QW'(q_ff);
   always_comb begin
      if (num_ff == '0) level = CENTRE_LEVEL;
      else if (q_wide > QW'(LEVEL_MAX)) level = LEVEL_MAX;
      else level = q_wide[LEVEL_W-1:0];
   end

   always_ff @(posedge clock) begin
      // Capture sample, seed or widen the range
      if (cmd.load) begin
         raw_ff <= raw_m;
         if (!seeded) begin
            lo_ff <= raw_m;
            hi_ff <= raw_m;
         end else begin
            if (raw_m < lo_ff) lo_ff <= raw_m;
            if (raw_m > hi_ff) hi_ff <= raw_m;
         end
      end
      // Form range and offset
      if (cmd.prep) begin
         num_ff  <= hi_ff - lo_ff;
         diff_ff <= raw_ff - lo_ff;
      end
      // Scale the range down to one level step
      if (cmd.step) begin
         num_ff <= AW'(scaled >> SH);
      end
      // Align the step under the top quotient bit
      if (cmd.lprep) begin
         dv_ff <= {num_ff, {(RW-1){1'b0}}};
         q_ff  <= '0;
      end
      // Advance offset / step by one quotient bit
      if (cmd.level) begin
         if (lvl_ge) diff_ff <= diff_ff - dv_ff[AW-1:0];
         q_ff  <= {q_ff[RW-2:0], lvl_ge};
         dv_ff <= dv_ff >> 1;
      end
   end

endmodule

@@ hw/rtl/jac_dp.sv @@
// Datapath: two axis lanes, configuration registers, cursor and response register.
module jac_dp #(
   parameter int AXIS_BITS = jac_pkg::AXIS_BITS_DEF,
   parameter int LEVELS    = jac_pkg::LEVELS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  jac_pkg::jac_cmd_type        cmd,
   output jac_pkg::jac_sts_type        sts,
   input  logic [jac_pkg::RAW_W-1:0]   raw_x,
   input  logic [jac_pkg::RAW_W-1:0]   raw_y,
   input  logic [jac_pkg::BTN_W-1:0]   buttons,
   jac_rsp_if.source                   rsp_chan,
   jac_csr_if.sink                     csr_chan
);
   import jac_pkg::*;

   logic                 cal_ff, quit_ff;
   logic [CUR_X_W-1:0]   x_limit_ff, pos_x_ff, pos_x_in;
   logic [CUR_Y_W-1:0]   y_limit_ff, pos_y_ff, pos_y_in;
   logic [THR_W-1:0]     low_thr_ff, high_thr_ff;
   logic [LEVEL_W-1:0]   lvl_x, lvl_y;

   logic                 rsp_valid_ff;
   logic [LEVEL_W-1:0]   rsp_lx_ff, rsp_ly_ff;
   logic [CUR_X_W-1:0]   rsp_cx_ff;
   logic [CUR_Y_W-1:0]   rsp_cy_ff;
   logic                 rsp_quit_ff;

   // Step one axis toward the level, then clamp to the limit
   function automatic logic [CUR_X_W-1:0] move_axis(
      input logic [CUR_X_W-1:0] pos,
      input logic [LEVEL_W-1:0] lvl,
      input logic [THR_W-1:0]   lo_thr,
      input logic [THR_W-1:0]   hi_thr,
      input logic [CUR_X_W-1:0] limit
   );
      logic [CUR_X_W:0] p;
      p = {1'b0, pos};
      if (lvl < lo_thr) begin
         if (pos != '0) p = p - 1'b1;
      end else if (lvl > hi_thr) begin
         p = p + 1'b1;
      end
      if (p > {1'b0, limit}) p = {1'b0, limit};
      return p[CUR_X_W-1:0];
   endfunction

   jac_axis #(.AXIS_BITS(AXIS_BITS), .LEVELS(LEVELS)) u_axis_x (
      .clock  (clock),
      .cmd    (cmd),
      .seeded (cal_ff),
      .raw    (raw_x),
      .level  (lvl_x)
   );

   jac_axis #(.AXIS_BITS(AXIS_BITS), .LEVELS(LEVELS)) u_axis_y (
      .clock  (clock),
      .cmd    (cmd),
      .seeded (cal_ff),
      .raw    (raw_y),
      .level  (lvl_y)
   );

   // Next cursor position, held on quit
   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      if (!quit_ff) begin
         pos_x_in = move_axis(pos_x_ff, lvl_x, low_thr_ff, high_thr_ff, x_limit_ff);
         pos_y_in = CUR_Y_W'(move_axis(CUR_X_W'(pos_y_ff), lvl_y, low_thr_ff,
                                       high_thr_ff, CUR_X_W'(y_limit_ff)));
      end
   end

   assign sts.out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign csr_chan.ready = 1'b1;

   // Control state: calibration flag, cursor, registers, response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff       <= 1'b0;
         pos_x_ff     <= POS_X_RESET;
         pos_y_ff     <= POS_Y_RESET;
         x_limit_ff   <= X_LIMIT_RESET;
         y_limit_ff   <= Y_LIMIT_RESET;
         low_thr_ff   <= LOW_THR_RESET;
         high_thr_ff  <= HIGH_THR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) cal_ff <= 1'b1;
         if (cmd.commit) begin
            pos_x_ff <= pos_x_in;
            pos_y_ff <= pos_y_in;
         end
         if (csr_chan.valid) begin
            case (csr_index_type'(csr_chan.index))
               CSR_X_LIMIT:  x_limit_ff  <= csr_chan.data;
               CSR_Y_LIMIT:  y_limit_ff  <= csr_chan.data[CUR_Y_W-1:0];
               CSR_LOW_THR:  low_thr_ff  <= csr_chan.data[THR_W-1:0];
               CSR_HIGH_THR: high_thr_ff <= csr_chan.data[THR_W-1:0];
               default: ;
            endcase
         end
         if (cmd.commit) rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;
      end
   end

   // Payload: quit flag per request, response fields
   always_ff @(posedge clock) begin
      if (cmd.load) quit_ff <= (buttons == BTN_BOTH_PRESSED);
      if (cmd.commit) begin
         rsp_lx_ff   <= lvl_x;
         rsp_ly_ff   <= lvl_y;
         rsp_cx_ff   <= pos_x_in;
         rsp_cy_ff   <= pos_y_in;
         rsp_quit_ff <= quit_ff;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.level_x  = rsp_lx_ff;
   assign rsp_chan.level_y  = rsp_ly_ff;
   assign rsp_chan.cursor_x = rsp_cx_ff;
   assign rsp_chan.cursor_y = rsp_cy_ff;
   assign rsp_chan.quit     = rsp_quit_ff;

endmodule

@@ hw/rtl/jac_checker.sv @@
// Port-level checker for the joystick cursor block, bound to the top level.
module jac_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [jac_pkg::LEVEL_W-1:0]      rsp_level_x,
   input logic [jac_pkg::LEVEL_W-1:0]      rsp_level_y,
   input logic [jac_pkg::CUR_X_W-1:0]      rsp_cursor_x,
   input logic [jac_pkg::CUR_Y_W-1:0]      rsp_cursor_y,
   input logic                             rsp_quit,
   input logic                             csr_ready
);

   // Busy right after taking a request
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while previous one in flight");

   // Response valid does not rise early after a request is taken
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> ##1 !$rose(rsp_valid))
      else $error("response appeared too early");

   // Held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_level_x)
         && $stable(rsp_level_y) && $stable(rsp_cursor_x)
         && $stable(rsp_cursor_y) && $stable(rsp_quit))
      else $error("stalled response changed");

   // Register port never stalls
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("register port stalled");

endmodule

bind joystick_autocal_cursor_top jac_checker u_jac_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_level_x  (rsp_chan.level_x),
   .rsp_level_y  (rsp_chan.level_y),
   .rsp_cursor_x (rsp_chan.cursor_x),
   .rsp_cursor_y (rsp_chan.cursor_y),
   .rsp_quit     (rsp_chan.quit),
   .csr_ready    (csr_chan.ready)
);

@@ dv/joystick_cursor_checker.sv @@
// Checker for the joystick cursor block: predicts each response and compares it.
`timescale 1ns / 1ps

module joystick_cursor_checker (
   input  logic clock,
   input  logic reset,
   jac_req_if   req_mon,
   jac_rsp_if   rsp_mon,
   jac_csr_if   csr_mon,
   output int   mismatch_count,
   output int   steps_in_flight
);
   import jac_pkg::*;

   localparam int LEVELS     = LEVELS_DEF;
   localparam int PRINT_CAP  = 40;

   typedef struct packed {
      logic [LEVEL_W-1:0] level_x;
      logic [LEVEL_W-1:0] level_y;
      logic [CUR_X_W-1:0] cursor_x;
      logic [CUR_Y_W-1:0] cursor_y;
      logic               quit;
   } cursor_step_type;

   // Register copies
   logic [CUR_X_W-1:0] x_limit;
   logic [CUR_Y_W-1:0] y_limit;
   logic [THR_W-1:0]   low_thr;
   logic [THR_W-1:0]   high_thr;

   // Calibration and cursor state
   logic [RAW_W-1:0]   min_x, max_x, min_y, max_y;
   logic               calibrated;
   logic [CUR_X_W-1:0] pos_x;
   logic [CUR_Y_W-1:0] pos_y;

   cursor_step_type expected_steps[$];
   int              printed = 0;

   initial begin
      mismatch_count  = 0;
      steps_in_flight = 0;
   end

   // Count the failure and print one line, up to PRINT_CAP lines
   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (printed < PRINT_CAP) begin
         printed++;
         $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      end
   endtask

   // Normalize one axis against its seen range; centre level when the step is zero
   function automatic logic [LEVEL_W-1:0] axis_level(input logic [RAW_W-1:0] raw,
                                                     input logic [RAW_W-1:0] lo,
                                                     input logic [RAW_W-1:0] hi);
      logic [RAW_W-1:0] span_step;
      logic [RAW_W-1:0] quotient;
      span_step = (hi - lo) / RAW_W'(LEVELS);
      if (span_step == '0) return CENTRE_LEVEL;
      quotient = (raw - lo) / span_step;
      if (quotient > RAW_W'(LEVEL_MAX)) return LEVEL_MAX;
      return quotient[LEVEL_W-1:0];
   endfunction

   // Step one axis by the level against the thresholds, then clamp to 0..limit
   function automatic int move_axis(input int pos, input logic [LEVEL_W-1:0] lvl,
                                    input int limit);
      int p;
      p = pos;
      if (lvl < low_thr) p--;
      else if (lvl > high_thr) p++;
      if (p < 0) p = 0;
      if (p > limit) p = limit;
      return p;
   endfunction

   always @(posedge clock) begin
      cursor_step_type got;
      cursor_step_type want;
      logic [LEVEL_W-1:0] lx;
      logic [LEVEL_W-1:0] ly;
      logic quit_now;
      if (reset) begin
         x_limit    = X_LIMIT_RESET;
         y_limit    = Y_LIMIT_RESET;
         low_thr    = LOW_THR_RESET;
         high_thr   = HIGH_THR_RESET;
         min_x      = '0;
         max_x      = '0;
         min_y      = '0;
         max_y      = '0;
         calibrated = 1'b0;
         pos_x      = POS_X_RESET;
         pos_y      = POS_Y_RESET;
         expected_steps.delete();
      end else begin
         // Compare an accepted response with the oldest expectation
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.level_x, rsp_mon.level_y, rsp_mon.cursor_x,
                    rsp_mon.cursor_y, rsp_mon.quit};
            if (expected_steps.size() == 0) begin
               report_mismatch("unexpected response, cursor_x", got.cursor_x, -1);
            end else begin
               want = expected_steps.pop_front();
               if (got.level_x != want.level_x)
                  report_mismatch("level_x", got.level_x, want.level_x);
               if (got.level_y != want.level_y)
                  report_mismatch("level_y", got.level_y, want.level_y);
               if (got.cursor_x != want.cursor_x)
                  report_mismatch("cursor_x", got.cursor_x, want.cursor_x);
               if (got.cursor_y != want.cursor_y)
                  report_mismatch("cursor_y", got.cursor_y, want.cursor_y);
               if (got.quit != want.quit)
                  report_mismatch("quit", got.quit, want.quit);
            end
         end

         // Advance calibration and cursor for an accepted request
         if (req_mon.valid && req_mon.ready) begin
            if (!calibrated) begin
               min_x      = req_mon.raw_x;
               max_x      = req_mon.raw_x;
               min_y      = req_mon.raw_y;
               max_y      = req_mon.raw_y;
               calibrated = 1'b1;
            end
            if (req_mon.raw_x > max_x) max_x = req_mon.raw_x;
            if (req_mon.raw_x < min_x) min_x = req_mon.raw_x;
            if (req_mon.raw_y > max_y) max_y = req_mon.raw_y;
            if (req_mon.raw_y < min_y) min_y = req_mon.raw_y;
            lx       = axis_level(req_mon.raw_x, min_x, max_x);
            ly       = axis_level(req_mon.raw_y, min_y, max_y);
            quit_now = (req_mon.buttons == BTN_BOTH_PRESSED);
            // Quit holds the cursor where it is
            if (!quit_now) begin
               pos_x = CUR_X_W'(move_axis(pos_x, lx, x_limit));
               pos_y = CUR_Y_W'(move_axis(pos_y, ly, y_limit));
            end
            want = '{lx, ly, pos_x, pos_y, quit_now};
            expected_steps.push_back(want);
         end

         // Track register writes
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_X_LIMIT:  x_limit  = csr_mon.data[CUR_X_W-1:0];
               CSR_Y_LIMIT:  y_limit  = csr_mon.data[CUR_Y_W-1:0];
               CSR_LOW_THR:  low_thr  = csr_mon.data[THR_W-1:0];
               CSR_HIGH_THR: high_thr = csr_mon.data[THR_W-1:0];
               default: ;
            endcase
         end
      end
      steps_in_flight = expected_steps.size();
   end

endmodule

@@ dv/joystick_autocal_cursor_top_tb.sv @@
// Testbench top for the joystick cursor block: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module joystick_autocal_cursor_top_tb;
   import jac_pkg::*;

   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int SETTLE_CYCLES   = RAW_W + $clog2(2 * LEVELS_DEF) + 4 + 8;
   localparam int HOLD_CYCLES     = 300;
   localparam int IDLE_PCT        = 34;

   logic clock;
   logic reset;

   jac_req_if req_chan ();
   jac_rsp_if rsp_chan ();
   jac_csr_if csr_chan ();

   int mismatch_count;
   int steps_in_flight;

   // Flow-control knobs for the request side (tx_quiet) and the response side (rx_quiet, hold_arm)
   bit tx_quiet = 1'b0;
   bit rx_quiet = 1'b0;
   bit hold_arm = 1'b0;

   joystick_autocal_cursor_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   joystick_cursor_checker cursor_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .csr_mon         (csr_chan),
      .mismatch_count  (mismatch_count),
      .steps_in_flight (steps_in_flight)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Hard limit on the run
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   // Drive one register write and wait for it to be taken
   task automatic write_register(input csr_index_type idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // Offer one request after a random gap unless tx_quiet; return at the accepting edge
   task automatic send_sample(input logic [RAW_W-1:0] rx, input logic [RAW_W-1:0] ry,
                              input logic [BTN_W-1:0] btn);
      @(negedge clock);
      while (!tx_quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.raw_x   <= rx;
      req_chan.raw_y   <= ry;
      req_chan.buttons <= btn;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Drop the request and wait until every response is back
   task automatic drain_results;
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (steps_in_flight != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Raw sample for a push direction: low, centre, high, or anywhere
   function automatic logic [RAW_W-1:0] pick_raw(input int dir);
      case (dir)
         -1:      return RAW_W'($urandom_range(0, 150));
         0:       return RAW_W'($urandom_range(420, 600));
         1:       return RAW_W'($urandom_range(870, 1023));
         default: return RAW_W'($urandom_range(0, 1023));
      endcase
   endfunction

   // Response side: random stalls, a quiet stretch, and one long hold-off
   initial begin
      int hold_left;
      hold_left      = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (hold_arm) begin
            hold_arm  = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= rx_quiet || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // Request side and verdict
   initial begin
      int phase;
      int k;
      int burst_left;
      int dir_x;
      int dir_y;
      logic [RAW_W-1:0]      rx;
      logic [RAW_W-1:0]      ry;
      logic [BTN_W-1:0]      btn;
      logic [CSR_DATA_W-1:0] cfg [4];

      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.raw_x   = '0;
      req_chan.raw_y   = '0;
      req_chan.buttons = '1;
      csr_chan.valid   = 1'b0;
      csr_chan.index   = CSR_X_LIMIT;
      csr_chan.data    = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: seeding, zero range step, extremes, quit, all button codes
      send_sample(10'd512, 10'd512, 2'b11);
      send_sample(10'd515, 10'd509, 2'b10);
      send_sample(10'd0,   10'd1023, 2'b01);
      send_sample(10'd1023, 10'd0, 2'b11);
      send_sample(10'd0,   10'd0,   BTN_BOTH_PRESSED);
      send_sample(10'd1023, 10'd1023, BTN_BOTH_PRESSED);
      send_sample(10'd511, 10'd511, 2'b11);
      send_sample(10'd1,   10'd1022, 2'b11);
      send_sample(10'd1022, 10'd1, 2'b10);
      send_sample(10'd682, 10'd341, 2'b01);
      send_sample(10'h155, 10'h2AA, 2'b11);
      send_sample(10'h2AA, 10'h155, BTN_BOTH_PRESSED);
      drain_results();

      // Directed: zero limits pin the cursor, quit at a pinned cursor
      write_register(CSR_X_LIMIT, 7'd0);
      write_register(CSR_Y_LIMIT, 7'd0);
      send_sample(10'd600, 10'd600, 2'b11);
      send_sample(10'd1023, 10'd1023, 2'b11);
      send_sample(10'd0, 10'd0, BTN_BOTH_PRESSED);
      send_sample(10'd0, 10'd1023, 2'b11);
      drain_results();

      // Random phases, each under its own register settings
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: cfg = '{7'd78,  7'd24, 7'd2,  7'd5};
            1: cfg = '{7'd127, 7'd31, 7'd11, 7'd0};
            2: cfg = '{7'd1,   7'd1,  7'd6,  7'd6};
            3: cfg = '{7'd127, 7'd31, 7'd0,  7'd11};
            4: cfg = '{7'd3,   7'd2,  7'd0,  7'd15};
            5: cfg = '{7'd100, 7'd20, 7'd15, 7'd12};
            default: begin
               cfg[0] = 7'($urandom_range(1, 127));
               cfg[1] = 7'($urandom_range(1, 31));
               cfg[2] = 7'($urandom_range(0, 11));
               cfg[3] = 7'($urandom_range(0, 11));
            end
         endcase
         write_register(CSR_X_LIMIT,  cfg[0]);
         write_register(CSR_Y_LIMIT,  cfg[1]);
         write_register(CSR_LOW_THR,  cfg[2]);
         write_register(CSR_HIGH_THR, cfg[3]);

         burst_left = 0;
         for (k = 0; k < ITEMS_PER_PHASE; k++) begin
            // Mostly held stick directions, so the cursor reaches its limits
            if (burst_left == 0) begin
               burst_left = $urandom_range(4, 40);
               if ($urandom_range(0, 99) < 70) begin
                  dir_x = int'($urandom_range(0, 2)) - 1;
                  dir_y = int'($urandom_range(0, 2)) - 1;
               end else begin
                  dir_x = 2;
                  dir_y = 2;
               end
            end
            burst_left--;
            rx = pick_raw(dir_x);
            ry = pick_raw(dir_y);
            if (dir_x == 2)
               btn = BTN_W'($urandom_range(0, 3));
            else if ($urandom_range(0, 99) < 6)
               btn = BTN_BOTH_PRESSED;
            else
               btn = BTN_W'($urandom_range(1, 3));
            send_sample(rx, ry, btn);

            // First phase runs without any idling after its first item
            if (k == 0) begin
               tx_quiet = (phase == 0);
               rx_quiet = (phase == 0);
            end
            if (phase == 3 && k == 20) hold_arm = 1'b1;
            if (phase == 1 && k == 60) drain_results();
         end
         drain_results();
      end

      if (mismatch_count == 0 && steps_in_flight == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

@@ joystick_autocal_cursor_top.f @@
hw/rtl/jac_pkg.sv
hw/rtl/jac_if.sv
hw/rtl/jac_ctrl.sv
hw/rtl/jac_axis.sv
hw/rtl/jac_dp.sv
hw/rtl/joystick_autocal_cursor_top.sv
hw/rtl/jac_checker.sv
dv/joystick_cursor_checker.sv
dv/joystick_autocal_cursor_top_tb.sv
